// ===== src/bmc_pkg.sv =====
package bmc_pkg;

  localparam int CFG_W      = 12;
  localparam int REG_IDX_W  = 1;
  localparam int PIX_W      = 8;
  localparam int OUT_XY_W   = 11;
  localparam int OUT_CNT_W  = 23;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  localparam logic [PIX_W-1:0] OBJECT_LEVEL = 8'd255;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } bmc_state_t;

  typedef struct packed {
    logic accept;    // pixel word taken this cycle
    logic launch;    // frame ends: snapshot sums into divider, clear accumulators
    logic step;      // one quotient bit
    logic load_out;  // move quotients into the result register
  } bmc_cmd_t;

  typedef struct packed {
    logic last_pixel;  // current position is the last of the frame
  } bmc_sts_t;

endpackage

// ===== src/binary_mask_centroid.sv =====
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------------------
// in       | input     | in_valid / in_stall  | in_pixel_value
// out      | output    | out_valid / out_stall| out_centroid_x/_y, out_object_pixel_count,
//          |           |                      | out_frame_empty
// cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// One pixel word per cycle while in_stall is low; one result word per frame.
// The frame's last word starts a restoring divider, one quotient bit per cycle for both
// coordinates; the quotients are then moved into the output register.
// in_stall rises only on the last word of the next frame while that divide or its
// delivery into the output register is still pending.
// Synchronous active-low reset clears positions, sums and control; sizes return to 640x480.
module binary_mask_centroid
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_XY_W-1:0]  out_centroid_x,
  output logic [OUT_XY_W-1:0]  out_centroid_y,
  output logic [OUT_CNT_W-1:0] out_object_pixel_count,
  output logic                 out_frame_empty
);

  localparam int PX_W  = $clog2(MAX_WIDTH);
  localparam int PY_W  = $clog2(MAX_HEIGHT);
  localparam int STEPS = (PX_W > PY_W) ? PX_W : PY_W;

  bmc_cmd_t cmd;
  bmc_sts_t sts;

  bmc_ctrl #(
    .STEPS(STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmc_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_pixel_value        (in_pixel_value),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_centroid_x        (out_centroid_x),
    .out_centroid_y        (out_centroid_y),
    .out_object_pixel_count(out_object_pixel_count),
    .out_frame_empty       (out_frame_empty)
  );

endmodule

// ===== src/bmc_ctrl.sv =====
module bmc_ctrl
  import bmc_pkg::*;
#(
  parameter int STEPS = 11
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  bmc_sts_t sts,
  output bmc_cmd_t cmd
);

  localparam int SC_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  bmc_state_t      state_r, state_nxt;
  logic [SC_W-1:0] step_cnt_r, step_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  // only the word that closes a frame has to wait for the divider
  assign in_stall = sts.last_pixel && (state_r != ST_IDLE);

  always_comb begin
    cmd.accept   = in_valid && !in_stall;
    cmd.launch   = cmd.accept && sts.last_pixel;
    cmd.step     = (state_r == ST_DIV);
    cmd.load_out = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.launch) begin
          state_nxt    = ST_DIV;
          step_cnt_nxt = SC_W'(STEPS - 1);
        end
      end
      ST_DIV: begin
        if (step_cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end else begin
          step_cnt_nxt = step_cnt_r - SC_W'(1);
        end
      end
      ST_HOLD: begin
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_launch_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.launch |=> state_r == ST_DIV)
    else $error("frame end did not start the divider");

  a_no_end_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.last_pixel) |-> state_r == ST_IDLE)
    else $error("frame closed while divider busy");

  a_div_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_cnt_r == '0) |=> state_r == ST_HOLD)
    else $error("divider did not finish after last step");

  a_hold_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && !out_valid_r) |=> out_valid_r)
    else $error("finished result not loaded into free output register");
`endif

endmodule

// ===== src/bmc_dpath.sv =====
module bmc_dpath
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [PIX_W-1:0]     in_pixel_value,
  input  bmc_cmd_t             cmd,
  output bmc_sts_t             sts,
  output logic [OUT_XY_W-1:0]  out_centroid_x,
  output logic [OUT_XY_W-1:0]  out_centroid_y,
  output logic [OUT_CNT_W-1:0] out_object_pixel_count,
  output logic                 out_frame_empty
);

  localparam int PX_W  = $clog2(MAX_WIDTH);
  localparam int PY_W  = $clog2(MAX_HEIGHT);
  localparam int QW    = (PX_W > PY_W) ? PX_W : PY_W;
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SX_W  = PX_W + CNT_W;
  localparam int SY_W  = PY_W + CNT_W;
  localparam int EXW   = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int EYW   = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic [PX_W-1:0]  col_r;
  logic [PY_W-1:0]  row_r;
  logic [SX_W-1:0]  sum_x_r;
  logic [SY_W-1:0]  sum_y_r;
  logic [CNT_W-1:0] cnt_r;

  // divider: both lanes share the divisor and the step
  logic [CNT_W-1:0] div_d_r;
  logic [CNT_W:0]   rem_x_r, rem_y_r;
  logic [QW-1:0]    num_x_r, num_y_r;
  logic [QW-1:0]    quo_x_r, quo_y_r;

  logic [OUT_XY_W-1:0]  res_x_r, res_y_r;
  logic [OUT_CNT_W-1:0] res_cnt_r;
  logic                 res_empty_r;

  logic [EXW-1:0]   eff_w, col_inc;
  logic [EYW-1:0]   eff_h, row_inc;
  logic             col_end, row_end, hit;
  logic [SX_W-1:0]  sum_x_add;
  logic [SY_W-1:0]  sum_y_add;
  logic [CNT_W-1:0] cnt_add;
  logic [CNT_W:0]   d_ext, trial_x, trial_y;
  logic             ge_x, ge_y;
  logic [QW+OUT_XY_W-1:0]     quo_x_wide, quo_y_wide;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    priority if (frame_width_r == '0) begin
      eff_w = EXW'(1);
    end else if (EXW'(frame_width_r) > EXW'(MAX_WIDTH)) begin
      eff_w = EXW'(MAX_WIDTH);
    end else begin
      eff_w = EXW'(frame_width_r);
    end
    priority if (frame_height_r == '0) begin
      eff_h = EYW'(1);
    end else if (EYW'(frame_height_r) > EYW'(MAX_HEIGHT)) begin
      eff_h = EYW'(MAX_HEIGHT);
    end else begin
      eff_h = EYW'(frame_height_r);
    end
  end

  assign col_inc = EXW'(col_r) + EXW'(1);
  assign row_inc = EYW'(row_r) + EYW'(1);
  assign col_end = !(col_inc < eff_w);
  assign row_end = !(row_inc < eff_h);
  assign sts.last_pixel = col_end && row_end;

  assign hit       = (in_pixel_value == OBJECT_LEVEL);
  assign sum_x_add = sum_x_r + (hit ? SX_W'(col_r) : '0);
  assign sum_y_add = sum_y_r + (hit ? SY_W'(row_r) : '0);
  assign cnt_add   = cnt_r + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.accept) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : PY_W'(row_inc);
      end else begin
        col_r <= PX_W'(col_inc);
      end
      if (cmd.launch) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        cnt_r   <= '0;
      end else begin
        sum_x_r <= sum_x_add;
        sum_y_r <= sum_y_add;
        cnt_r   <= cnt_add;
      end
    end
  end

  // quotient fits in QW bits, so the top of the sum is already below the divisor
  assign d_ext   = {1'b0, div_d_r};
  assign trial_x = {rem_x_r[CNT_W-1:0], num_x_r[QW-1]};
  assign trial_y = {rem_y_r[CNT_W-1:0], num_y_r[QW-1]};
  assign ge_x    = !(trial_x < d_ext);
  assign ge_y    = !(trial_y < d_ext);

  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      div_d_r <= cnt_add;
      rem_x_r <= (CNT_W+1)'(sum_x_add >> QW);
      rem_y_r <= (CNT_W+1)'(sum_y_add >> QW);
      num_x_r <= sum_x_add[QW-1:0];
      num_y_r <= sum_y_add[QW-1:0];
      quo_x_r <= '0;
      quo_y_r <= '0;
    end else if (cmd.step) begin
      rem_x_r <= ge_x ? (trial_x - d_ext) : trial_x;
      rem_y_r <= ge_y ? (trial_y - d_ext) : trial_y;
      num_x_r <= num_x_r << 1;
      num_y_r <= num_y_r << 1;
      quo_x_r <= {quo_x_r[QW-2:0], ge_x};
      quo_y_r <= {quo_y_r[QW-2:0], ge_y};
    end
  end

  assign quo_x_wide = {{OUT_XY_W{1'b0}}, quo_x_r};
  assign quo_y_wide = {{OUT_XY_W{1'b0}}, quo_y_r};
  assign cnt_wide   = {{OUT_CNT_W{1'b0}}, div_d_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_empty_r <= (div_d_r == '0);
      res_cnt_r   <= cnt_wide[OUT_CNT_W-1:0];
      // the divider result is meaningless for an empty frame
      res_x_r     <= (div_d_r == '0) ? '0 : quo_x_wide[OUT_XY_W-1:0];
      res_y_r     <= (div_d_r == '0) ? '0 : quo_y_wide[OUT_XY_W-1:0];
    end
  end

  assign out_centroid_x         = res_x_r;
  assign out_centroid_y         = res_y_r;
  assign out_object_pixel_count = res_cnt_r;
  assign out_frame_empty        = res_empty_r;

endmodule

// ===== tb/tb_binary_mask_centroid.sv =====
module tb_binary_mask_centroid
  import bmc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_WAIT  = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PIXELS  = 250;

  typedef struct packed {
    logic [OUT_XY_W-1:0]  cx;
    logic [OUT_XY_W-1:0]  cy;
    logic [OUT_CNT_W-1:0] cnt;
    logic                 empty;
  } centroid_t;

  typedef enum logic [2:0] {
    FILL_NONE,   // no object pixel
    FILL_FULL,   // every pixel 255
    FILL_LAST,   // only the final word of the frame is 255
    FILL_NEAR,   // anything but 255
    FILL_RAND    // half object, half other values
  } fill_t;

  typedef struct {
    int               pre;     // words sent at the old size before the writes
    bit               set_w;
    bit               set_h;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    fill_t            fill;
    int               npix;
    bit               typed;
    centroid_t        want;
  } frame_row_t;

  localparam centroid_t NO_C    = '0;
  localparam centroid_t EMPTY_C = '{11'd0, 11'd0, 23'd0, 1'b1};

  frame_row_t plan [10] = '{
    // one column at the reset height of 480 rows, only the last row marked
    '{0,    1'b1, 1'b0, 12'd1,    12'd0,    FILL_LAST, 480,  1'b1,
      '{11'd0, 11'd479, 23'd1, 1'b0}},
    '{0,    1'b1, 1'b1, 12'd1,    12'd1,    FILL_NONE, 1,    1'b1, EMPTY_C},
    '{0,    1'b1, 1'b1, 12'd1,    12'd1,    FILL_FULL, 1,    1'b1,
      '{11'd0, 11'd0, 23'd1, 1'b0}},
    // zero sizes act as one
    '{0,    1'b1, 1'b1, 12'd0,    12'd0,    FILL_FULL, 1,    1'b1,
      '{11'd0, 11'd0, 23'd1, 1'b0}},
    '{0,    1'b1, 1'b1, 12'd8,    12'd4,    FILL_NEAR, 32,   1'b1, EMPTY_C},
    '{0,    1'b1, 1'b1, 12'd3,    12'd5,    FILL_FULL, 15,   1'b1,
      '{11'd1, 11'd2, 23'd15, 1'b0}},
    '{0,    1'b1, 1'b1, 12'd7,    12'd3,    FILL_RAND, 21,   1'b0, NO_C},
    // narrow the row while the column is already past the new end
    '{5,    1'b1, 1'b0, 12'd4,    12'd0,    FILL_RAND, 9,    1'b0, NO_C},
    // shorten the frame while the row is already past the new end
    '{9,    1'b0, 1'b1, 12'd0,    12'd2,    FILL_RAND, 3,    1'b0, NO_C},
    '{0,    1'b1, 1'b1, 12'd5,    12'd4,    FILL_RAND, 20,   1'b0, NO_C}
  };

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index      = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [OUT_XY_W-1:0]  out_centroid_x;
  logic [OUT_XY_W-1:0]  out_centroid_y;
  logic [OUT_CNT_W-1:0] out_object_pixel_count;
  logic                 out_frame_empty;

  binary_mask_centroid u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_pixel_value         (in_pixel_value),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_centroid_x         (out_centroid_x),
    .out_centroid_y         (out_centroid_y),
    .out_object_pixel_count (out_object_pixel_count),
    .out_frame_empty        (out_frame_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the block's registers and accumulators
  logic [CFG_W-1:0]     width_reg  = RST_FRAME_WIDTH;
  logic [CFG_W-1:0]     height_reg = RST_FRAME_HEIGHT;
  logic [32:0]          col_acc    = '0;
  logic [32:0]          row_acc    = '0;
  logic [OUT_CNT_W-1:0] hit_total  = '0;
  logic [10:0]          col_at     = '0;
  logic [10:0]          row_at     = '0;

  centroid_t centroid_q [$];
  centroid_t typed_want;
  bit        typed_armed = 1'b0;
  bit        no_gaps     = 1'b0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;
  int        hold_left   = 0;
  int        free_left   = 0;
  int        busy_left   = 0;
  int        errors      = 0;
  int        results_seen = 0;
  int        pixels_sent  = 0;
  int        reg_writes   = 0;
  int        stall_cycles = 0;
  int        cycle_count  = 0;

  function automatic int clamp_size(logic [CFG_W-1:0] v, int max_v);
    if (v == '0) return 1;
    if (int'(v) > max_v) return max_v;
    return int'(v);
  endfunction

  // advance the shadow by one pixel; returns 1 when the frame closes
  function automatic bit centroid_step(input logic [PIX_W-1:0] pix, output centroid_t res);
    int w;
    int h;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    res = '0;
    if (pix == OBJECT_LEVEL) begin
      col_acc   = col_acc + 33'(col_at);
      row_acc   = row_acc + 33'(row_at);
      hit_total = hit_total + 1'b1;
    end
    if (int'(col_at) + 1 < w) begin
      col_at = col_at + 1'b1;
      return 1'b0;
    end
    col_at = '0;
    if (int'(row_at) + 1 < h) begin
      row_at = row_at + 1'b1;
      return 1'b0;
    end
    row_at = '0;
    if (hit_total == '0) begin
      res = EMPTY_C;
    end else begin
      res.cx  = OUT_XY_W'(col_acc / hit_total);
      res.cy  = OUT_XY_W'(row_acc / hit_total);
      res.cnt = hit_total;
    end
    col_acc   = '0;
    row_acc   = '0;
    hit_total = '0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel(int pct);
    if ($urandom_range(0, 99) < pct) return OBJECT_LEVEL;
    return PIX_W'($urandom_range(0, 254));
  endfunction

  function automatic logic [PIX_W-1:0] pixel_for(fill_t fill, int k, int n);
    case (fill)
      FILL_NONE: return '0;
      FILL_FULL: return OBJECT_LEVEL;
      FILL_LAST: return (k == n - 1) ? OBJECT_LEVEL : PIX_W'($urandom_range(0, 254));
      FILL_NEAR: return PIX_W'($urandom_range(0, 254));
      default:   return rand_pixel(50);
    endcase
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("[%0t] result %0d %s: got %0d, want %0d", $realtime, results_seen, what, got,
             want);
    errors++;
  endtask

  // offer one word, hold it until taken, then update the shadow
  task automatic push_pixel(input logic [PIX_W-1:0] pix, output bit done);
    int        gap;
    centroid_t res;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    @(posedge clk);
    while (in_stall) begin
      stall_cycles++;
      @(posedge clk);
    end
    pixels_sent++;
    done = centroid_step(pix, res);
    if (done) begin
      if (typed_armed) begin
        centroid_q.push_back(typed_want);
        typed_armed = 1'b0;
      end else begin
        centroid_q.push_back(res);
      end
    end
  endtask

  // drop valid, wait for every pending result and let the divider go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (centroid_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic compare_result();
    centroid_t want;
    if (centroid_q.size() == 0) begin
      flag_mismatch("unexpected result", 1, 0);
      return;
    end
    want = centroid_q.pop_front();
    if (out_centroid_x !== want.cx) flag_mismatch("centroid_x", out_centroid_x, want.cx);
    if (out_centroid_y !== want.cy) flag_mismatch("centroid_y", out_centroid_y, want.cy);
    if (out_object_pixel_count !== want.cnt) begin
      flag_mismatch("object_pixel_count", out_object_pixel_count, want.cnt);
    end
    if (out_frame_empty !== want.empty) begin
      flag_mismatch("frame_empty", out_frame_empty, want.empty);
    end
    results_seen++;
  endtask

  // receiver: check taken words, stall at random, one long hold on request
  always @(posedge clk) begin : result_side
    int roll;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) compare_result();
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (free_left != 0) begin
        out_stall <= 1'b0;
        free_left <= free_left - 1;
      end else if (busy_left != 0) begin
        out_stall <= 1'b1;
        busy_left <= busy_left - 1;
      end else begin
        out_stall <= 1'b0;
        roll = $urandom_range(0, 99);
        free_left <= (roll < 70) ? $urandom_range(1, 8) :
                     (roll < 92) ? $urandom_range(20, 60) : $urandom_range(100, 300);
        busy_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) :
                     $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int base;
    int frame_no;
    int pct;
    bit done;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      no_gaps = (i % 3 == 0);
      for (int k = 0; k < plan[i].pre; k++) push_pixel(rand_pixel(50), done);
      settle();
      if (plan[i].set_w) write_reg(REG_FRAME_WIDTH, plan[i].w);
      if (plan[i].set_h) write_reg(REG_FRAME_HEIGHT, plan[i].h);
      typed_armed = plan[i].typed;
      typed_want  = plan[i].want;
      for (int k = 0; k < plan[i].npix; k++) begin
        push_pixel(pixel_for(plan[i].fill, k, plan[i].npix), done);
      end
    end
    settle();

    // tiny frames back to back while the receiver holds off: the block must stall
    write_reg(REG_FRAME_WIDTH, 12'd2);
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    hold_req <= 1'b1;
    base     = pixels_sent;
    frame_no = 0;
    while (pixels_sent - base < RAND_PIXELS) begin
      if (frame_no >= 16 && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          // resize part way through a frame
          repeat ($urandom_range(1, 3)) push_pixel(rand_pixel(50), done);
          settle();
          write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, 10)));
        end else begin
          settle();
          if ($urandom_range(0, 24) == 0) begin
            write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(11, 64)));
            write_reg(REG_FRAME_HEIGHT, 12'd1);
          end else begin
            write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, 10)));
            write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 6)));
          end
        end
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 6))
        0:       pct = 0;
        1:       pct = 100;
        default: pct = $urandom_range(10, 90);
      endcase
      done = 1'b0;
      while (!done) push_pixel(rand_pixel(pct), done);
      frame_no++;
    end
    settle();

    $display("covered %0d pixel words, %0d frame results, %0d register writes",
             pixels_sent, results_seen, reg_writes);
    $display("input held off for %0d cycles, one receiver hold of %0d cycles",
             stall_cycles, HOLD_CYCLES);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bmc_pkg.sv
src/bmc_ctrl.sv
src/bmc_dpath.sv
src/binary_mask_centroid.sv
tb/tb_binary_mask_centroid.sv
